// ===== rtl/world_to_radar_projection_assert.svh =====
// assertion macros for the port-level radar projection checker
`ifndef WORLD_TO_RADAR_PROJECTION_ASSERT_SVH
`define WORLD_TO_RADAR_PROJECTION_ASSERT_SVH

// implication checked only outside reset
`define W2R_ASSERT_RUN(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// implication checked at every edge, reset included
`define W2R_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> cons) \
    else $error(msg);

`endif

// ===== rtl/w2r_pkg.sv =====
// types, constants and tables of the radar projection pipeline
package w2r_pkg;

  localparam int COORD_FRAC_BITS = 8;
  localparam int ANGLE_BITS      = 16;
  localparam int PIXEL_BITS      = 12;
  localparam int CLAMP_MARGIN    = 4;

  localparam int COORD_W    = 24;
  localparam int YAW_W      = 16;
  localparam int WIDTH_W    = 12;
  localparam int ZOOM_W     = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_RADAR_WIDTH = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_ZOOM_SCALE  = CFG_ADDR_W'(1);

  localparam logic [WIDTH_W-1:0] RADAR_WIDTH_RST = WIDTH_W'(256);
  localparam logic [ZOOM_W-1:0]  ZOOM_SCALE_RST  = ZOOM_W'(4096);

  localparam int CORDIC_STEPS    = 24;
  localparam int STEPS_PER_STAGE = 3;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam int CORDIC_W        = 33;
  localparam int TRIG_W          = 32;

  localparam logic signed [CORDIC_W-1:0] INV_GAIN_Q30 = CORDIC_W'(652032874);

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN32 [0:CORDIC_STEPS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  localparam int DXY_W      = COORD_W + 1;
  localparam int PROD_W     = DXY_W + TRIG_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int NORM_SHIFT = 22 + COORD_FRAC_BITS;
  localparam int MAG_W      = NUM_W - 1 - NORM_SHIFT;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = (MAG_W + DIV_BITS - 1) / DIV_BITS;
  localparam int QUO_W      = DIV_STAGES * DIV_BITS;
  localparam int Q_W        = QUO_W + 1;
  localparam int POS_W      = QUO_W + 2;

  localparam int CORDIC_LAT = CORDIC_STAGES + 1;
  localparam int PIPE_DEPTH = CORDIC_LAT + DIV_STAGES + 5;
  localparam int LATENCY    = PIPE_DEPTH + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] observer_x;
    logic signed [COORD_W-1:0] observer_y;
    logic        [YAW_W-1:0]   view_yaw;
  } req_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] radar_x;
    logic [PIXEL_BITS-1:0] radar_y;
  } res_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
  } cstate_t;

  typedef logic signed [DXY_W-1:0]  dxy_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic        [MAG_W-1:0]  mag_t;
  typedef logic        [QUO_W-1:0]  quo_t;
  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic        [ZOOM_W-1:0] zoom_t;

endpackage

// ===== rtl/w2r_cordic.sv =====
// pipelined rotation cordic giving cosine and sine of a binary angle in q30
module w2r_cordic (
  input  logic                        clk,
  input  logic [w2r_pkg::YAW_W-1:0]   angle,
  output w2r_pkg::trig_t              cosine,
  output w2r_pkg::trig_t              sine
);

  localparam int CW = w2r_pkg::CORDIC_W;
  localparam int NS = w2r_pkg::CORDIC_STAGES;
  localparam int AB = w2r_pkg::ANGLE_BITS;

  function automatic w2r_pkg::cstate_t cordic_step(w2r_pkg::cstate_t v, int i);
    w2r_pkg::cstate_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;
    xs = v.x >>> i;
    ys = v.y >>> i;
    at = {1'b0, w2r_pkg::ATAN_TURN32[i]};
    r = v;
    if (!v.z[CW-1]) begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - at;
    end else begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + at;
    end
    return r;
  endfunction

  function automatic w2r_pkg::cstate_t cordic_stage(w2r_pkg::cstate_t v, int base);
    w2r_pkg::cstate_t r;
    r = v;
    for (int j = 0; j < w2r_pkg::STEPS_PER_STAGE; j++) begin
      r = cordic_step(r, base + j);
    end
    return r;
  endfunction

  logic [31:0]      ang;
  w2r_pkg::cstate_t seed;
  w2r_pkg::cstate_t st [0:NS-1];
  logic [1:0]       quad [0:NS-1];

  assign ang    = {angle[AB-1:0], {(32 - AB){1'b0}}};
  assign seed.x = w2r_pkg::INV_GAIN_Q30;
  assign seed.y = '0;
  assign seed.z = {3'b000, ang[29:0]};

  always_ff @(posedge clk) begin
    st[0]   <= cordic_stage(seed, 0);
    quad[0] <= ang[31:30];
    for (int k = 1; k < NS; k++) begin
      st[k]   <= cordic_stage(st[k-1], k * w2r_pkg::STEPS_PER_STAGE);
      quad[k] <= quad[k-1];
    end
  end

  // quadrant rotation
  always_ff @(posedge clk) begin
    case (quad[NS-1])
      2'd0: begin
        cosine <= w2r_pkg::trig_t'(st[NS-1].x);
        sine   <= w2r_pkg::trig_t'(st[NS-1].y);
      end
      2'd1: begin
        cosine <= w2r_pkg::trig_t'(-st[NS-1].y);
        sine   <= w2r_pkg::trig_t'(st[NS-1].x);
      end
      2'd2: begin
        cosine <= w2r_pkg::trig_t'(-st[NS-1].x);
        sine   <= w2r_pkg::trig_t'(-st[NS-1].y);
      end
      default: begin
        cosine <= w2r_pkg::trig_t'(st[NS-1].y);
        sine   <= w2r_pkg::trig_t'(-st[NS-1].x);
      end
    endcase
  end

endmodule

// ===== rtl/w2r_div.sv =====
// pipelined restoring divider, a few quotient bits per stage, sign carried along
module w2r_div (
  input  logic                clk,
  input  w2r_pkg::zoom_t      divisor,
  input  w2r_pkg::mag_t       dividend,
  input  logic                sign,
  output w2r_pkg::quo_t       quotient,
  output logic                quotient_sign
);

  localparam int ZW = w2r_pkg::ZOOM_W;
  localparam int QW = w2r_pkg::QUO_W;
  localparam int NS = w2r_pkg::DIV_STAGES;

  typedef struct packed {
    logic [ZW-1:0] rem;
    logic [QW-1:0] dq;
    logic          neg;
  } div_t;

  function automatic div_t div_stage(div_t v, logic [ZW-1:0] d);
    div_t        r;
    logic [ZW:0] t;
    logic [ZW:0] diff;
    r = v;
    for (int j = 0; j < w2r_pkg::DIV_BITS; j++) begin
      t    = {r.rem, r.dq[QW-1]};
      diff = t - {1'b0, d};
      r.dq = {r.dq[QW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r.rem   = diff[ZW-1:0];
        r.dq[0] = 1'b1;
      end else begin
        r.rem = t[ZW-1:0];
      end
    end
    return r;
  endfunction

  div_t seed;
  div_t stg [0:NS-1];

  assign seed.rem = '0;
  assign seed.dq  = QW'(dividend);
  assign seed.neg = sign;

  always_ff @(posedge clk) begin
    stg[0] <= div_stage(seed, divisor);
    for (int k = 1; k < NS; k++) begin
      stg[k] <= div_stage(stg[k-1], divisor);
    end
  end

  assign quotient      = stg[NS-1].dq;
  assign quotient_sign = stg[NS-1].neg;

endmodule

// ===== rtl/world_to_radar_projection.sv =====
// top level: world offset rotated by view yaw, scaled by zoom, clamped to the radar
//
//  channel   signals                                   transfer
//  request   start, busy, request                      start & !busy
//  result    done, result                              done, one cycle
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid & cfg_ready
//
//  one request per cycle outside reset, while busy is low
//  latency is set by the 8-stage cordic, the 7-stage zoom divider and 7 more
//  stages for offset, quadrant, products, sums, magnitude, sign and clamp
//  busy and cfg_ready follow rst; reset drops requests in flight
//  the result side never stalls, so neither does the pipeline
module world_to_radar_projection (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  w2r_pkg::req_t                      request,
  output logic                               done,
  output w2r_pkg::res_t                      result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [w2r_pkg::CFG_ADDR_W-1:0]     cfg_index,
  input  logic [w2r_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int PD = w2r_pkg::PIPE_DEPTH;
  localparam int CL = w2r_pkg::CORDIC_LAT;
  localparam int PB = w2r_pkg::PIXEL_BITS;
  localparam w2r_pkg::pos_t MARGIN = w2r_pkg::pos_t'(w2r_pkg::CLAMP_MARGIN);

  logic [w2r_pkg::WIDTH_W-1:0] radar_width;
  logic [w2r_pkg::ZOOM_W-1:0]  zoom_scale;
  w2r_pkg::zoom_t              zoom_eff;
  logic [PD:0]                 vld;
  logic                        accept;

  w2r_pkg::dxy_t               dx0;
  w2r_pkg::dxy_t               dy0;
  logic [w2r_pkg::YAW_W-1:0]   yaw0;
  w2r_pkg::dxy_t               dxd [0:CL-1];
  w2r_pkg::dxy_t               dyd [0:CL-1];
  w2r_pkg::trig_t              c;
  w2r_pkg::trig_t              s;
  w2r_pkg::prod_t              p_xs;
  w2r_pkg::prod_t              p_yc;
  w2r_pkg::prod_t              p_xc;
  w2r_pkg::prod_t              p_ys;
  w2r_pkg::num_t               nx;
  w2r_pkg::num_t               ny;
  logic [w2r_pkg::NUM_W-1:0]   ax;
  logic [w2r_pkg::NUM_W-1:0]   ay;
  w2r_pkg::mag_t               mx;
  w2r_pkg::mag_t               my;
  logic                        sx;
  logic                        sy;
  w2r_pkg::quo_t               quo_x;
  w2r_pkg::quo_t               quo_y;
  logic                        neg_x;
  logic                        neg_y;
  w2r_pkg::q_t                 qx;
  w2r_pkg::q_t                 qy;
  w2r_pkg::pos_t               w_s;
  w2r_pkg::pos_t               xv;
  w2r_pkg::pos_t               yv;
  w2r_pkg::pos_t               xr;
  w2r_pkg::pos_t               yr;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;
  assign zoom_eff  = (zoom_scale == '0) ? w2r_pkg::zoom_t'(1) : zoom_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      radar_width <= w2r_pkg::RADAR_WIDTH_RST;
      zoom_scale  <= w2r_pkg::ZOOM_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        w2r_pkg::REG_RADAR_WIDTH: radar_width <= cfg_data[w2r_pkg::WIDTH_W-1:0];
        w2r_pkg::REG_ZOOM_SCALE:  zoom_scale  <= cfg_data[w2r_pkg::ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PD-1:0], accept};
    end
  end

  // offsets of the target from the observer
  always_ff @(posedge clk) begin
    dx0  <= w2r_pkg::dxy_t'(request.target_x) - w2r_pkg::dxy_t'(request.observer_x);
    dy0  <= w2r_pkg::dxy_t'(request.target_y) - w2r_pkg::dxy_t'(request.observer_y);
    yaw0 <= request.view_yaw;
  end

  w2r_cordic u_cordic (
    .clk    (clk),
    .angle  (yaw0),
    .cosine (c),
    .sine   (s)
  );

  always_ff @(posedge clk) begin
    dxd[0] <= dx0;
    dyd[0] <= dy0;
    for (int k = 1; k < CL; k++) begin
      dxd[k] <= dxd[k-1];
      dyd[k] <= dyd[k-1];
    end
  end

  always_ff @(posedge clk) begin
    p_xs <= dxd[CL-1] * s;
    p_yc <= dyd[CL-1] * c;
    p_xc <= dxd[CL-1] * c;
    p_ys <= dyd[CL-1] * s;
  end

  always_ff @(posedge clk) begin
    nx <= w2r_pkg::num_t'(p_xs) - w2r_pkg::num_t'(p_yc);
    ny <= -(w2r_pkg::num_t'(p_xc) + w2r_pkg::num_t'(p_ys));
  end

  // magnitude, then truncating shift by the fixed part of the denominator
  assign ax = nx[w2r_pkg::NUM_W-1] ? -nx : nx;
  assign ay = ny[w2r_pkg::NUM_W-1] ? -ny : ny;

  always_ff @(posedge clk) begin
    mx <= ax[w2r_pkg::NUM_W-2:w2r_pkg::NORM_SHIFT];
    my <= ay[w2r_pkg::NUM_W-2:w2r_pkg::NORM_SHIFT];
    sx <= nx[w2r_pkg::NUM_W-1];
    sy <= ny[w2r_pkg::NUM_W-1];
  end

  w2r_div u_div_x (
    .clk           (clk),
    .divisor       (zoom_eff),
    .dividend      (mx),
    .sign          (sx),
    .quotient      (quo_x),
    .quotient_sign (neg_x)
  );

  w2r_div u_div_y (
    .clk           (clk),
    .divisor       (zoom_eff),
    .dividend      (my),
    .sign          (sy),
    .quotient      (quo_y),
    .quotient_sign (neg_y)
  );

  always_ff @(posedge clk) begin
    qx <= neg_x ? -w2r_pkg::q_t'(quo_x) : w2r_pkg::q_t'(quo_x);
    qy <= neg_y ? -w2r_pkg::q_t'(quo_y) : w2r_pkg::q_t'(quo_y);
  end

  // center and clamp, x and y each their own way
  always_comb begin
    w_s = w2r_pkg::pos_t'(radar_width);
    xv  = w2r_pkg::pos_t'(radar_width >> 1) + w2r_pkg::pos_t'(qx);
    yv  = w2r_pkg::pos_t'(radar_width >> 1) + w2r_pkg::pos_t'(qy);
    if (xv > w_s) begin
      xr = (w_s > MARGIN) ? w_s - MARGIN : '0;
    end else if (xv < MARGIN) begin
      xr = MARGIN;
    end else begin
      xr = xv;
    end
    if (yv > w_s) begin
      yr = w_s;
    end else if (yv < MARGIN) begin
      yr = '0;
    end else begin
      yr = yv;
    end
  end

  always_ff @(posedge clk) begin
    result.radar_x <= xr[PB-1:0];
    result.radar_y <= yr[PB-1:0];
  end

  assign done = vld[PD];

endmodule

// ===== rtl/w2r_checker.sv =====
// port-level checker for the radar projection, bound to the top level
`include "world_to_radar_projection_assert.svh"

module w2r_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `W2R_ASSERT_RUN(a_request_gives_done, start && !busy, ##(w2r_pkg::LATENCY) done, "request without result at fixed latency")
  `W2R_ASSERT_RUN(a_done_has_request, done, $past(start && !busy, w2r_pkg::LATENCY), "result without matching request")
  `W2R_ASSERT_ALWAYS(a_reset_flushes, rst, ##1 !done, "result right after reset")

endmodule

bind world_to_radar_projection w2r_checker u_w2r_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// ===== tb/world_to_radar_projection_checker.sv =====
`timescale 1ns / 1ps
// checker for the radar projection: tracks registers, predicts pixel positions, compares results
module world_to_radar_projection_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  w2r_pkg::req_t                  request,
  input  logic                           done,
  input  w2r_pkg::res_t                  result,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [w2r_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [w2r_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding,
  output int                             checked
);
  import w2r_pkg::*;

  localparam longint UNIT_VEC_Q30 = 64'sd652032874;
  localparam longint TURN_ATAN [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic [WIDTH_W-1:0] radar_w;
  logic [ZOOM_W-1:0]  zoom_q88;
  res_t               pixel_queue [$];

  function automatic void yaw_to_trig(input logic [YAW_W-1:0] yaw,
                                      output longint cos_q30, output longint sin_q30);
    logic [31:0] turn;
    longint      x, y, z, xs, ys;
    int          i;
    turn = 32'(yaw) << (32 - ANGLE_BITS);
    z = longint'(turn[29:0]);
    x = UNIT_VEC_Q30;
    y = 0;
    for (i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - TURN_ATAN[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + TURN_ATAN[i];
      end
    end
    case (turn[31:30])
      2'd0: begin cos_q30 = x;  sin_q30 = y;  end
      2'd1: begin cos_q30 = -y; sin_q30 = x;  end
      2'd2: begin cos_q30 = -x; sin_q30 = -y; end
      default: begin cos_q30 = y; sin_q30 = -x; end
    endcase
  endfunction

  function automatic res_t project_to_radar(input req_t r);
    longint dx, dy, c, s, den, qx, qy, w, half, xv, yv, margin;
    res_t   p;
    dx = longint'($signed(r.target_x)) - longint'($signed(r.observer_x));
    dy = longint'($signed(r.target_y)) - longint'($signed(r.observer_y));
    yaw_to_trig(r.view_yaw, c, s);
    den = longint'((zoom_q88 == '0) ? ZOOM_W'(1) : zoom_q88) << (22 + COORD_FRAC_BITS);
    qx = (dx * s - dy * c) / den;
    qy = -(dx * c + dy * s) / den;
    w = longint'(radar_w);
    half = w >> 1;
    margin = longint'(CLAMP_MARGIN);
    xv = half + qx;
    yv = half + qy;
    if (xv > w) xv = (w > margin) ? w - margin : 0;
    else if (xv < margin) xv = margin;
    if (yv > w) yv = w;
    else if (yv < margin) yv = 0;
    p.radar_x = PIXEL_BITS'(xv);
    p.radar_y = PIXEL_BITS'(yv);
    return p;
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    if (mismatches < 10)
      $display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      radar_w  = RADAR_WIDTH_RST;
      zoom_q88 = ZOOM_SCALE_RST;
      pixel_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RADAR_WIDTH: radar_w = cfg_data[WIDTH_W-1:0];
          REG_ZOOM_SCALE:  zoom_q88 = cfg_data[ZOOM_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        pixel_queue.push_back(project_to_radar(request));
      if (done) begin
        if (pixel_queue.size() == 0) begin
          note_mismatch("result with no request pending", -1, int'(result));
        end else begin
          want = pixel_queue.pop_front();
          checked++;
          if (result.radar_x !== want.radar_x)
            note_mismatch("radar_x", int'(want.radar_x), int'(result.radar_x));
          if (result.radar_y !== want.radar_y)
            note_mismatch("radar_y", int'(want.radar_y), int'(result.radar_y));
        end
      end
    end
    outstanding = pixel_queue.size();
  end

endmodule

// ===== tb/tb_world_to_radar_projection.sv =====
`timescale 1ns / 1ps
// testbench top for the radar projection: reset, register settings, request stimulus, verdict
module tb_world_to_radar_projection;
  import w2r_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = CFG_ADDR_W'(3);
  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  req_t                  request   = '0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  busy;
  logic                  done;
  logic                  cfg_ready;
  res_t                  result;

  int mismatches, outstanding, checked;
  int sent = 0;
  int reg_writes = 0;
  int settings = 1;
  logic [WIDTH_W-1:0] cur_width = RADAR_WIDTH_RST;
  logic [ZOOM_W-1:0]  cur_zoom  = ZOOM_SCALE_RST;

  world_to_radar_projection dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  world_to_radar_projection_checker chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("timeout: results still outstanding = %0d", outstanding);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic req_t make_req(input int tx, input int ty, input int ox, input int oy,
                                    input int yaw);
    req_t q;
    q.target_x   = COORD_W'(tx);
    q.target_y   = COORD_W'(ty);
    q.observer_x = COORD_W'(ox);
    q.observer_y = COORD_W'(oy);
    q.view_yaw   = YAW_W'(yaw);
    return q;
  endfunction

  // offset of k pixels and a half at the reset zoom
  function automatic int px(input int k);
    return k * 4096 + ((k < 0) ? -2048 : 2048);
  endfunction

  function automatic int corner_coord();
    case ($urandom_range(0, 5))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int corner_yaw();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 16'h3FFF;
      2: return 16'h4000;
      3: return 16'h8000;
      4: return 16'hC000;
      5: return 16'hFFFF;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic req_t random_req();
    int mode, zeff, span, ox, oy, dx, dy;
    mode = $urandom_range(0, 99);
    if (mode < 55) begin
      zeff = (cur_zoom == '0) ? 1 : int'(cur_zoom);
      span = zeff * (int'(cur_width >> 1) + 16);
      if (span > 4194304) span = 4194304;
      ox = int'($urandom_range(0, 8388608)) - 4194304;
      oy = int'($urandom_range(0, 8388608)) - 4194304;
      dx = int'($urandom_range(0, 2 * span)) - span;
      dy = int'($urandom_range(0, 2 * span)) - span;
      return make_req(ox + dx, oy + dy, ox, oy, int'($urandom));
    end else if (mode < 80) begin
      return make_req(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                      int'($urandom));
    end
    return make_req(corner_coord(), corner_coord(), corner_coord(), corner_coord(),
                    corner_yaw());
  endfunction

  task automatic send_req(input req_t r);
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(1, 16);
    start   <= 1'b0;
    request <= random_req();
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      REG_RADAR_WIDTH: cur_width = data[WIDTH_W-1:0];
      REG_ZOOM_SCALE:  cur_zoom = data[ZOOM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic new_setting(input logic [CFG_DATA_W-1:0] width_data,
                             input logic [CFG_DATA_W-1:0] zoom_data, input bit spare);
    drain();
    write_reg(REG_RADAR_WIDTH, width_data);
    write_reg(REG_ZOOM_SCALE, zoom_data);
    if (spare) begin
      write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
      write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic run_batch(input int n, input int idle_pct);
    int i;
    for (i = 0; i < n; i++) begin
      send_req(random_req());
      if (int'($urandom_range(0, 99)) < idle_pct) idle_gap();
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero offset, at the origin and at the coordinate extremes
    send_req(make_req(0, 0, 0, 0, 0));
    send_req(make_req(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 16'hFFFF));
    // widest offsets in every quadrant, then a short on-screen offset
    send_req(make_req(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 0));
    send_req(make_req(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 16'h4000));
    send_req(make_req(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 16'h8000));
    send_req(make_req(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 16'hC000));
    send_req(make_req(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 16'hFFFF));
    send_req(make_req(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 16'h2000));
    send_req(make_req(0, px(10), 0, 0, 0));
    // on-screen points across the quadrant boundaries
    send_req(make_req(px(20), px(7), 0, 0, 16'h3FFF));
    send_req(make_req(px(20), px(7), 0, 0, 16'h4000));
    send_req(make_req(px(20), px(7), 0, 0, 16'h7FFF));
    send_req(make_req(px(20), px(7), 0, 0, 16'h8000));
    send_req(make_req(px(20), px(7), 0, 0, 16'hBFFF));
    send_req(make_req(px(20), px(7), 0, 0, 16'hC000));
    // x clamp: past the right edge, at the edge, below the margin, at the margin
    send_req(make_req(0, px(-129), 0, 0, 0));
    send_req(make_req(0, -128 * 4096, 0, 0, 0));
    send_req(make_req(0, px(125), 0, 0, 0));
    send_req(make_req(0, px(124), 0, 0, 0));
    // y clamp: past the bottom, below the margin, at the margin
    send_req(make_req(px(-129), 0, 0, 0, 0));
    send_req(make_req(px(125), 0, 0, 0, 0));
    send_req(make_req(px(124), 0, 0, 0, 0));

    run_batch(60, 30);
    new_setting(16'd4095, 16'd256, 1'b0);
    run_batch(60, 25);
    new_setting(16'd8, 16'd65535, 1'b0);
    run_batch(60, 50);
    new_setting(16'd0, 16'd0, 1'b0);
    run_batch(60, 20);
    new_setting(16'd3, 16'd1, 1'b0);
    run_batch(60, 0);
    new_setting(16'd4, 16'd256, 1'b0);
    run_batch(60, 40);
    new_setting(16'hF064, 16'd300, 1'b1);
    run_batch(60, 25);
    new_setting(CFG_DATA_W'($urandom_range(8, 4095)), CFG_DATA_W'($urandom_range(256, 65535)),
                1'b0);
    run_batch(60, 30);
    new_setting(CFG_DATA_W'(RADAR_WIDTH_RST), CFG_DATA_W'(ZOOM_SCALE_RST), 1'b0);
    run_batch(100, 0);

    drain();
    repeat (LATENCY + 8) @(negedge clk);

    $display("%0d requests sent, %0d results checked, %0d mismatches", sent, checked,
             mismatches);
    $display("%0d register writes over %0d radar width and zoom settings", reg_writes, settings);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== world_to_radar_projection.f =====
+incdir+rtl
rtl/w2r_pkg.sv
rtl/w2r_cordic.sv
rtl/w2r_div.sv
rtl/world_to_radar_projection.sv
rtl/w2r_checker.sv
tb/world_to_radar_projection_checker.sv
tb/tb_world_to_radar_projection.sv
